// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file tga_checker.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define AST_HOLD(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed: property does not hold");

// Expression must never be true outside reset.
`define AST_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed: forbidden condition seen");

`endif

// ===== src/tga_pkg.sv =====
// Shared types and constants of the TGA stream decoder.
// No dependencies; imported by every module of the block.
package tga_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        has_alpha;
    logic [7:0]  repeat_count;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        image_done;
    logic [2:0]  error_code;
  } out_beat_t;

  // Result of the decode logic for one byte.
  typedef struct packed {
    logic      valid;
    out_beat_t beat;
  } core_res_t;

  localparam logic [2:0] ErrNone  = 3'd0;
  localparam logic [2:0] ErrType  = 3'd1;
  localparam logic [2:0] ErrSize  = 3'd2;
  localparam logic [2:0] ErrMany  = 3'd3;
  localparam logic [2:0] ErrTrunc = 3'd4;

  localparam int         HdrLen    = 12;
  localparam logic [3:0] TypeIdx   = 4'd2;
  localparam logic [7:0] TypeRaw   = 8'd2;
  localparam logic [7:0] TypeRle   = 8'd10;
  localparam logic [7:0] RunBias   = 8'd127;
  localparam logic [7:0] DepthRgb  = 8'd24;
  localparam logic [7:0] DepthRgba = 8'd32;

  // Expected byte of the fixed 12-byte header; only the type byte differs.
  function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input logic rle);
    logic [7:0] val;
    val = 8'd0;
    if (idx == TypeIdx) begin
      val = rle ? TypeRle : TypeRaw;
    end
    return val;
  endfunction

endpackage

// ===== src/tga_in_reg.sv =====
// Input register stage of the TGA decoder.
// Depends on tga_pkg.
module tga_in_reg import tga_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_beat_t in_beat_i,
  input  logic     advance_i,
  output logic     valid_o,
  output in_beat_t beat_o
);

  logic     valid_q;
  in_beat_t beat_q;

  // hold the byte while the result side cannot take its outcome
  assign in_stall_o = valid_q && !advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      beat_q <= in_beat_i;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

// ===== src/tga_core.sv =====
// Decode state and per-byte update logic of the TGA decoder.
// Depends on tga_pkg.
module tga_core import tga_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_beat_t  beat_i,
  output core_res_t res_o
);

  typedef enum logic [2:0] {
    PhHeader,
    PhDims,
    PhPacket,
    PhPixel,
    PhDone,
    PhError
  } phase_e;

  localparam logic [4:0] PosWidthLo  = 5'd12;
  localparam logic [4:0] PosWidthHi  = 5'd13;
  localparam logic [4:0] PosHeightLo = 5'd14;
  localparam logic [4:0] PosHeightHi = 5'd15;
  localparam logic [4:0] PosDepth    = 5'd16;
  localparam logic [4:0] PosDesc     = 5'd17;

  phase_e      phase_q, phase_d;
  logic [4:0]  pos_q, pos_d;
  logic [1:0]  cand_q, cand_d;
  logic        comp_q, comp_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic        four_q, four_d;
  logic [23:0] pixb_q, pixb_d;
  logic        run_q, run_d;
  logic [7:0]  rem_q, rem_d;
  logic [32:0] cnt_q, cnt_d;
  logic [31:0] total_q, total_d;

  logic [7:0]  b;
  logic [1:0]  p;
  logic [1:0]  last_idx;
  logic [32:0] sum_one, sum_run, total_x;
  logic [7:0]  rem_next;
  logic [2:0]  err;
  logic        have_pix, done, active;
  logic [7:0]  pr, pg, pb, pa, rep;

  assign b        = beat_i.data_byte;
  assign p        = pos_q[1:0];
  assign last_idx = four_q ? 2'd3 : 2'd2;
  assign sum_one  = cnt_q + 33'd1;
  assign sum_run  = cnt_q + {25'd0, rem_q};
  assign total_x  = {1'b0, total_q};
  assign rem_next = (rem_q != 8'd0) ? rem_q - 8'd1 : 8'd0;
  assign active   = step_i && (phase_q != PhDone) && (phase_q != PhError);

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    cand_d   = cand_q;
    comp_d   = comp_q;
    width_d  = width_q;
    height_d = height_q;
    four_d   = four_q;
    pixb_d   = pixb_q;
    run_d    = run_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    total_d  = total_q;
    err      = ErrNone;
    have_pix = 1'b0;
    done     = 1'b0;
    pr       = 8'd0;
    pg       = 8'd0;
    pb       = 8'd0;
    pa       = 8'd0;
    rep      = 8'd0;

    unique case (phase_q)
      PhHeader: begin
        if (b != hdr_byte(pos_q[3:0], 1'b0)) cand_d[0] = 1'b0;
        if (b != hdr_byte(pos_q[3:0], 1'b1)) cand_d[1] = 1'b0;
        pos_d = pos_q + 5'd1;
        if (pos_q == 5'(HdrLen - 1)) phase_d = PhDims;
      end
      PhDims: begin
        unique case (pos_q)
          PosWidthLo:  width_d[7:0]   = b;
          PosWidthHi:  width_d[15:8]  = b;
          PosHeightLo: height_d[7:0]  = b;
          PosHeightHi: height_d[15:8] = b;
          PosDepth: begin
            pixb_d = {16'd0, b};
            four_d = (b == DepthRgba);
          end
          default: ;
        endcase
        if (pos_q == PosDesc) begin
          if (width_q == 16'd0 || height_q == 16'd0 ||
              (pixb_q != {16'd0, DepthRgb} && pixb_q != {16'd0, DepthRgba})) begin
            err = ErrSize;
          end else if (cand_q == 2'b00) begin
            err = ErrType;
          end else begin
            comp_d  = !cand_q[0];
            total_d = {16'd0, width_q} * {16'd0, height_q};
            cnt_d   = 33'd0;
            pixb_d  = 24'd0;
            pos_d   = 5'd0;
            phase_d = cand_q[0] ? PhPixel : PhPacket;
          end
        end else begin
          pos_d = pos_q + 5'd1;
        end
      end
      PhPacket: begin
        run_d   = b[7];
        rem_d   = b[7] ? b - RunBias : b + 8'd1;
        pos_d   = 5'd0;
        pixb_d  = 24'd0;
        phase_d = PhPixel;
      end
      PhPixel: begin
        if (p < last_idx) begin
          unique case (p)
            2'd0: pixb_d[7:0]   = b;
            2'd1: pixb_d[15:8]  = b;
            2'd2: pixb_d[23:16] = b;
            default: ;
          endcase
          pos_d = {3'd0, p} + 5'd1;
        end else begin
          pb     = pixb_q[7:0];
          pg     = pixb_q[15:8];
          pr     = four_q ? pixb_q[23:16] : b;
          pa     = four_q ? b : 8'd0;
          pixb_d = 24'd0;
          pos_d  = 5'd0;
          if (!comp_q) begin
            cnt_d    = sum_one;
            have_pix = 1'b1;
            rep      = 8'd1;
            if (sum_one >= total_x) begin
              done    = 1'b1;
              phase_d = PhDone;
            end
          end else if (run_q) begin
            cnt_d = sum_run;
            if (sum_run > total_x) begin
              err = ErrMany;
            end else begin
              have_pix = 1'b1;
              rep      = rem_q;
              rem_d    = 8'd0;
              if (sum_run == total_x) begin
                done    = 1'b1;
                phase_d = PhDone;
              end else begin
                phase_d = PhPacket;
              end
            end
          end else begin
            cnt_d = sum_one;
            if (sum_one > total_x) begin
              err = ErrMany;
            end else begin
              have_pix = 1'b1;
              rep      = 8'd1;
              rem_d    = rem_next;
              if (rem_next == 8'd0) begin
                if (sum_one == total_x) begin
                  done    = 1'b1;
                  phase_d = PhDone;
                end else begin
                  phase_d = PhPacket;
                end
              end
            end
          end
        end
      end
      default: ;
    endcase

    // early end of stream
    if (err == ErrNone && !done && beat_i.last_byte) err = ErrTrunc;
    if (err != ErrNone) phase_d = PhError;
  end

  always_comb begin
    res_o.valid             = active && (err != ErrNone || have_pix);
    res_o.beat.has_alpha    = four_d;
    res_o.beat.image_width  = width_d;
    res_o.beat.image_height = height_d;
    res_o.beat.error_code   = err;
    if (err != ErrNone) begin
      res_o.beat.red          = 8'd0;
      res_o.beat.green        = 8'd0;
      res_o.beat.blue         = 8'd0;
      res_o.beat.alpha        = 8'd0;
      res_o.beat.repeat_count = 8'd0;
      res_o.beat.image_done   = 1'b0;
    end else begin
      res_o.beat.red          = pr;
      res_o.beat.green        = pg;
      res_o.beat.blue         = pb;
      res_o.beat.alpha        = pa;
      res_o.beat.repeat_count = rep;
      res_o.beat.image_done   = done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHeader;
      pos_q    <= 5'd0;
      cand_q   <= 2'b11;
      comp_q   <= 1'b0;
      width_q  <= 16'd0;
      height_q <= 16'd0;
      four_q   <= 1'b0;
      pixb_q   <= 24'd0;
      run_q    <= 1'b0;
      rem_q    <= 8'd0;
      cnt_q    <= 33'd0;
      total_q  <= 32'd0;
    end else if (active) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      cand_q   <= cand_d;
      comp_q   <= comp_d;
      width_q  <= width_d;
      height_q <= height_d;
      four_q   <= four_d;
      pixb_q   <= pixb_d;
      run_q    <= run_d;
      rem_q    <= rem_d;
      cnt_q    <= cnt_d;
      total_q  <= total_d;
    end
  end

endmodule

// ===== src/tga_out_reg.sv =====
// Result register of the TGA decoder.
// Depends on tga_pkg.
module tga_out_reg import tga_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  core_res_t res_i,
  output logic      free_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  logic      valid_q;
  out_beat_t beat_q;

  // empty, or the held beat leaves at this edge
  assign free_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i && res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i && res_i.valid) begin
      beat_q <= res_i.beat;
    end
  end

  assign out_valid_o = valid_q;
  assign out_beat_o  = beat_q;

endmodule

// ===== src/tga_image_stream_decoder.sv =====
// Top level of the TGA (type 2 / type 10) byte stream decoder.
// Depends on tga_pkg, tga_in_reg, tga_core and tga_out_reg.
//
//   channel | dir | handshake             | payload
//   --------+-----+-----------------------+-------------------------------------
//   in      | in  | in_valid_i/in_stall_o | in_beat_t: data_byte, last_byte
//   out     | out | out_valid_o/out_stall_i | out_beat_t: color, repeat, size, status
//
// One file byte per cycle while the result side does not stall. A byte goes
// through the input register, then the decode logic (header match, size checks,
// 16x16 pixel-count multiply or 33-bit pixel-count add and compare) into the
// result register.
// Reset (async, active low) returns to header matching with empty registers.
// A stalled result holds; the input register then fills and in_stall_o rises.
module tga_image_stream_decoder import tga_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  logic      s1_valid;
  in_beat_t  s1_beat;
  logic      free;
  logic      step;
  core_res_t res;

  // a byte in the input register is decoded when the result register can take it
  assign step = s1_valid && free;

  tga_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .advance_i  (free),
    .valid_o    (s1_valid),
    .beat_o     (s1_beat)
  );

  // header/packet/pixel state; updates only on a decoded byte
  tga_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .beat_i (s1_beat),
    .res_o  (res)
  );

  tga_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_i       (res),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

// ===== src/tga_checker.sv =====
// Port-level checks for the TGA decoder, bound to the top level.
// Depends on tga_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tga_checker import tga_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_beat_t out_beat_o
);

  logic in_take;
  logic out_held;
  logic err_dirty;
  logic pix_empty;
  logic last_out;

  assign in_take   = in_valid_i && !in_stall_o;
  assign out_held  = out_valid_o && out_stall_i;
  assign err_dirty = out_beat_o.error_code != ErrNone &&
                     (out_beat_o.repeat_count != 8'd0 || out_beat_o.image_done ||
                      out_beat_o.red != 8'd0 || out_beat_o.alpha != 8'd0);
  assign pix_empty = out_beat_o.error_code == ErrNone && out_beat_o.repeat_count == 8'd0;
  assign last_out  = out_valid_o && !out_stall_i &&
                     (out_beat_o.error_code != ErrNone || out_beat_o.image_done);

  // stalled result beat holds
  `AST_HOLD(a_out_hold, clk_i, rst_ni, out_held |=> out_valid_o && $stable(out_beat_o))
  // error beats carry no red, no alpha, no repeat and no done flag
  `AST_NEVER(a_err_clean, clk_i, rst_ni, out_valid_o && err_dirty)
  // pixel beats always cover at least one pixel
  `AST_NEVER(a_pix_rep, clk_i, rst_ni, out_valid_o && pix_empty)
  // nothing follows a final beat
  `AST_HOLD(a_final, clk_i, rst_ni, last_out |=> !out_valid_o)
  // a fresh result beat traces back to a byte taken on the input
  `AST_HOLD(a_cause, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_take, 2))

endmodule

bind tga_image_stream_decoder tga_checker u_tga_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_beat_o  (out_beat_o)
);

// ===== tb/sv/tb.sv =====
// Self-checking bench for tga_image_stream_decoder: random TGA byte streams
// (type 2 and type 10) against an in-bench decoder, with random idle and stall.
// Depends on tga_pkg and the tga_image_stream_decoder RTL.
module tb;
  import tga_pkg::*;

  // Position of the descriptor byte, where size and type are judged.
  localparam int         DescPos = HdrLen + 5;
  // Packet header at or above this value starts a run.
  localparam logic [7:0] RunFlag = 8'd128;

  typedef enum logic [2:0] {
    DecHeader,
    DecDims,
    DecPacket,
    DecPixel,
    DecDone,
    DecError
  } dec_phase_e;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_beat_t  in_beat_i   = '0;
  logic      out_stall_i = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_beat_t out_beat_o;

  // File bytes still to send, and result beats the decoder still owes us.
  in_beat_t  file_q[$];
  out_beat_t pixel_q[$];

  int bytes_taken  = 0;
  int results_seen = 0;
  int fails        = 0;

  // Bench copy of the decoder state; reset values, since reset comes only once.
  dec_phase_e  dec_phase = DecHeader;
  int          byte_idx  = 0;
  logic [1:0]  type_ok   = 2'b11;   // bit 0 raw header still possible, bit 1 rle
  logic        rle_mode  = 1'b0;
  logic [15:0] img_w     = '0;
  logic [15:0] img_h     = '0;
  logic        rgba      = 1'b0;
  logic [23:0] pix_acc   = '0;     // depth byte while in the header, else B,G,R so far
  logic        run_pkt   = 1'b0;
  logic [7:0]  pkt_left  = '0;
  logic [32:0] pix_count = '0;
  logic [31:0] pix_total = '0;

  tga_image_stream_decoder DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o (out_beat_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Idle pattern rotates every 128 bytes taken: none, sender gaps, receiver
  // stalls, then both at a lighter rate.
  wire [1:0] idle_mode    = 2'((bytes_taken / 128) % 4);
  wire [6:0] send_gap_pct = (idle_mode == 2'd1) ? 7'd64 : (idle_mode == 2'd3) ? 7'd25 : 7'd0;
  wire [6:0] stall_pct    = (idle_mode == 2'd2) ? 7'd64 : (idle_mode == 2'd3) ? 7'd25 : 7'd0;

  // Decode one accepted byte and queue the result beat it owes, if any.
  function automatic void decode_byte(input in_beat_t beat);
    logic [7:0] b;
    logic [7:0] want_raw;
    logic [7:0] want_rle;
    logic [2:0] err;
    logic       have_pix;
    logic       img_done;
    logic [7:0] pr, pg, pb, pa, rep;
    int         p;
    int         comps;
    out_beat_t  res;
    b        = beat.data_byte;
    err      = ErrNone;
    have_pix = 1'b0;
    img_done = 1'b0;
    {pr, pg, pb, pa, rep} = '0;
    res      = '0;
    // once finished or failed, everything is ignored
    if (dec_phase == DecDone || dec_phase == DecError) return;
    case (dec_phase)
      DecHeader: begin
        p        = byte_idx % HdrLen;
        want_raw = (p == TypeIdx) ? TypeRaw : 8'd0;
        want_rle = (p == TypeIdx) ? TypeRle : 8'd0;
        if (b != want_raw) type_ok[0] = 1'b0;
        if (b != want_rle) type_ok[1] = 1'b0;
        byte_idx = p + 1;
        if (byte_idx == HdrLen) dec_phase = DecDims;
      end
      DecDims: begin
        case (byte_idx)
          HdrLen:     img_w[7:0]  = b;
          HdrLen + 1: img_w[15:8] = b;
          HdrLen + 2: img_h[7:0]  = b;
          HdrLen + 3: img_h[15:8] = b;
          HdrLen + 4: begin
            pix_acc = {16'd0, b};
            rgba    = (b == DepthRgba);
          end
          default: ;
        endcase
        if (byte_idx >= DescPos) begin
          // size and depth are judged before the header type
          if (img_w == '0 || img_h == '0 || (pix_acc != DepthRgb && pix_acc != DepthRgba)) begin
            err = ErrSize;
          end else if (type_ok == 2'b00) begin
            err = ErrType;
          end else begin
            rle_mode  = !type_ok[0];
            pix_total = 32'(img_w) * 32'(img_h);
            pix_count = '0;
            pix_acc   = '0;
            byte_idx  = 0;
            dec_phase = rle_mode ? DecPacket : DecPixel;
          end
        end else begin
          byte_idx++;
        end
      end
      DecPacket: begin
        if (b < RunFlag) begin
          run_pkt  = 1'b0;
          pkt_left = b + 8'd1;
        end else begin
          run_pkt  = 1'b1;
          pkt_left = b - RunBias;
        end
        byte_idx  = 0;
        pix_acc   = '0;
        dec_phase = DecPixel;
      end
      default: begin
        comps = rgba ? 4 : 3;
        p     = byte_idx & 3;
        if (p + 1 < comps) begin
          pix_acc  = pix_acc | (24'(b) << (8 * p));
          byte_idx = p + 1;
        end else begin
          // stored B,G,R[,A]; hand back as RGB
          pb = pix_acc[7:0];
          pg = pix_acc[15:8];
          if (rgba) begin
            pr = pix_acc[23:16];
            pa = b;
          end else begin
            pr = b;
            pa = 8'd0;
          end
          pix_acc  = '0;
          byte_idx = 0;
          if (!rle_mode) begin
            pix_count++;
            have_pix = 1'b1;
            rep      = 8'd1;
            if (pix_count >= pix_total) begin
              img_done  = 1'b1;
              dec_phase = DecDone;
            end
          end else if (run_pkt) begin
            pix_count += pkt_left;
            if (pix_count > pix_total) begin
              err = ErrMany;
            end else begin
              have_pix = 1'b1;
              rep      = pkt_left;
              pkt_left = '0;
              if (pix_count == pix_total) begin
                img_done  = 1'b1;
                dec_phase = DecDone;
              end else begin
                dec_phase = DecPacket;
              end
            end
          end else begin
            // raw packet may reach the count mid-packet; only the next pixel fails
            pix_count++;
            if (pix_count > pix_total) begin
              err = ErrMany;
            end else begin
              have_pix = 1'b1;
              rep      = 8'd1;
              if (pkt_left > 0) pkt_left--;
              if (pkt_left == 0) begin
                if (pix_count == pix_total) begin
                  img_done  = 1'b1;
                  dec_phase = DecDone;
                end else begin
                  dec_phase = DecPacket;
                end
              end
            end
          end
        end
      end
    endcase
    // early end mark: a pixel finished on this byte is dropped for the error
    if (err == ErrNone && !img_done && beat.last_byte) err = ErrTrunc;
    if (err != ErrNone) begin
      dec_phase          = DecError;
      res.has_alpha      = rgba;
      res.image_width    = img_w;
      res.image_height   = img_h;
      res.error_code     = err;
      pixel_q.push_back(res);
    end else if (have_pix) begin
      res.red          = pr;
      res.green        = pg;
      res.blue         = pb;
      res.alpha        = pa;
      res.has_alpha    = rgba;
      res.repeat_count = rep;
      res.image_width  = img_w;
      res.image_height = img_h;
      res.image_done   = img_done;
      res.error_code   = ErrNone;
      pixel_q.push_back(res);
    end
  endfunction

  // Random byte with the all-zero and all-one values weighted up.
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic put(input logic [7:0] b, input logic fin = 1'b0);
    in_beat_t beat;
    beat.data_byte = b;
    beat.last_byte = fin;
    file_q.push_back(beat);
  endtask

  task automatic put_pixels(input int n, input int comps);
    repeat (n * comps) put(rand_byte());
  endtask

  // Mark an early end at a random byte from lo onward and drop what follows.
  task automatic cut_stream(input int lo);
    int cut;
    cut = $urandom_range(lo, file_q.size() - 1);
    file_q[cut].last_byte = 1'b1;
    while (file_q.size() > cut + 1) void'(file_q.pop_back());
  endtask

  // Input side: sends queued bytes, decodes each beat as it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_beat_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        decode_byte(in_beat_i);
        bytes_taken++;
      end
      // a stalled beat holds; otherwise pick the next byte or a gap
      if (!in_valid_i || !in_stall_o) begin
        if (file_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          in_valid_i <= 1'b1;
          in_beat_i  <= file_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output side: random stall, every taken result beat checked in order.
  always @(posedge clk_i or negedge rst_ni) begin : result_check
    out_beat_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (pixel_q.size() == 0) begin
          $error("unexpected result beat: error_code %0d", out_beat_o.error_code);
          fails++;
        end else begin
          want = pixel_q.pop_front();
          if (out_beat_o.red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, out_beat_o.red); fails++;
          end
          if (out_beat_o.green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, out_beat_o.green); fails++;
          end
          if (out_beat_o.blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, out_beat_o.blue); fails++;
          end
          if (out_beat_o.alpha !== want.alpha) begin
            $error("alpha: expected %0d, got %0d", want.alpha, out_beat_o.alpha); fails++;
          end
          if (out_beat_o.has_alpha !== want.has_alpha) begin
            $error("has_alpha: expected %0d, got %0d", want.has_alpha, out_beat_o.has_alpha);
            fails++;
          end
          if (out_beat_o.repeat_count !== want.repeat_count) begin
            $error("repeat_count: expected %0d, got %0d", want.repeat_count,
                   out_beat_o.repeat_count);
            fails++;
          end
          if (out_beat_o.image_width !== want.image_width) begin
            $error("image_width: expected %0d, got %0d", want.image_width,
                   out_beat_o.image_width);
            fails++;
          end
          if (out_beat_o.image_height !== want.image_height) begin
            $error("image_height: expected %0d, got %0d", want.image_height,
                   out_beat_o.image_height);
            fails++;
          end
          if (out_beat_o.image_done !== want.image_done) begin
            $error("image_done: expected %0d, got %0d", want.image_done, out_beat_o.image_done);
            fails++;
          end
          if (out_beat_o.error_code !== want.error_code) begin
            $error("error_code: expected %0d, got %0d", want.error_code, out_beat_o.error_code);
            fails++;
          end
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Builds one file, runs it, then reports. The decoder handles one image per
  // reset, so the seed picks the image kind and how the file ends.
  initial begin : run_main
    int         scen;
    int         comps;
    int         w;
    int         h;
    int         left;
    int         n;
    int         stop_at;
    int         ending;
    int         body_start;
    int         bad_pos;
    logic [7:0] depth;
    logic [7:0] hb;
    logic       rle;
    logic       big;
    string      ending_name;

    scen  = $urandom_range(0, 11);  // 0 bad type, 1 bad size/depth, 2 cut in header
    rle   = ($urandom_range(0, 2) != 0);
    comps = ($urandom_range(0, 1) != 0) ? 4 : 3;
    if (rle) begin
      case ($urandom_range(0, 7))
        0:       begin w = 65535; h = 1;     end
        1:       begin w = 1;     h = 65535; end
        default: begin w = $urandom_range(1, 300); h = 18000 / w; end
      endcase
    end else begin
      w = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 64);
      h = (1900 / comps) / w;
    end
    // very large images (over 20000 pixels) use long runs only, to keep the byte count in line
    big     = (w * h > 20000);
    depth   = (comps == 4) ? DepthRgba : DepthRgb;
    bad_pos = -1;
    ending_name = "image completed";

    // broken header byte; with a size fault too, size must win
    if (scen == 0 || (scen == 1 && $urandom_range(0, 1) != 0)) bad_pos = $urandom_range(0, 11);
    if (scen == 1) begin
      case ($urandom_range(0, 3))
        0:       w = 0;
        1:       h = 0;
        default: begin
          do depth = rand_byte(); while (depth == DepthRgb || depth == DepthRgba);
        end
      endcase
    end

    for (int i = 0; i < HdrLen; i++) begin
      hb = (i == TypeIdx) ? (rle ? TypeRle : TypeRaw) : 8'd0;
      if (i == bad_pos) begin
        if (i == TypeIdx) begin
          do hb = rand_byte(); while (hb == TypeRaw || hb == TypeRle);
        end else begin
          hb = 8'($urandom_range(1, 255));
        end
      end
      put(hb);
    end
    put(8'(w));
    put(8'(w >> 8));
    put(8'(h));
    put(8'(h >> 8));
    put(depth);
    put(rand_byte());  // descriptor, ignored

    if (scen == 0) begin
      ending_name = "unsupported header type";
    end else if (scen == 1) begin
      ending_name = (bad_pos >= 0) ? "bad size or depth with bad type" : "bad size or depth";
    end else if (scen == 2) begin
      ending_name = "end mark inside the header";
      cut_stream(0);
    end else if (rle) begin
      left    = w * h;
      stop_at = 0;
      ending  = $urandom_range(0, 3);  // exact, early end, run overshoot, raw overshoot
      if (ending >= 2) stop_at = $urandom_range(1, 100);
      body_start = file_q.size();
      // packet header extremes up front: raw of 1, run of 1, run of 128, raw of 128
      if (left - stop_at >= 260) begin
        put(8'h00); put_pixels(1, comps);
        put(8'h80); put_pixels(1, comps);
        put(8'hFF); put_pixels(1, comps);
        put(8'h7F); put_pixels(128, comps);
        left -= 258;
      end
      while (left > stop_at) begin
        if (big || $urandom_range(0, 9) < 7) begin
          n = (big || $urandom_range(0, 1) != 0) ? 128 : $urandom_range(1, 128);
          if (n > left - stop_at) n = left - stop_at;
          put(8'(n + RunBias));
          put_pixels(1, comps);
        end else begin
          n = $urandom_range(1, 6);
          if (n > left - stop_at) n = left - stop_at;
          put(8'(n - 1));
          put_pixels(n, comps);
        end
        left -= n;
      end
      // here left == stop_at, below 128
      case (ending)
        1: begin
          ending_name = "end mark inside pixel data";
          cut_stream(body_start);
        end
        2: begin
          ending_name = "run past the pixel count";
          n = $urandom_range(left + 1, 128);
          put(8'(n + RunBias));
          put_pixels(1, comps);
        end
        3: begin
          ending_name = "raw packet past the pixel count";
          n = $urandom_range(left + 1, left + 6);
          put(8'(n - 1));
          put_pixels(n, comps);
        end
        default: file_q[$].last_byte = ($urandom_range(0, 1) != 0);
      endcase
    end else begin
      body_start = file_q.size();
      put_pixels(w * h, comps);
      if ($urandom_range(0, 1) != 0) begin
        ending_name = "end mark inside pixel data";
        cut_stream(body_start);
      end else begin
        file_q[$].last_byte = ($urandom_range(0, 1) != 0);
      end
    end
    // trailing bytes, padded out to a full-length stream: all must be ignored
    repeat ($urandom_range(4, 16)) put(rand_byte(), $urandom_range(0, 3) == 0);
    while (file_q.size() < 1900) put(rand_byte(), $urandom_range(0, 3) == 0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (file_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (pixel_q.size() != 0) @(posedge clk_i);
    // leave room for any stray beat to show up through the input and result registers
    repeat (16) @(posedge clk_i);

    $display("Ran a %0s file, %0dx%0d at depth %0d, ending: %0s.",
             rle ? "type 10" : "type 2", w, h, depth, ending_name);
    $display("%0d bytes taken, %0d result beats checked, %0d mismatches.",
             bytes_taken, results_seen, fails);
    if (fails == 0) begin
      $display("tga_image_stream_decoder regression: pass");
    end else begin
      $display("tga_image_stream_decoder regression: fail");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("tga_image_stream_decoder regression: fail");
    $finish;
  end

endmodule

// ===== tga_image_stream_decoder.f =====
+incdir+src
src/tga_pkg.sv
src/tga_in_reg.sv
src/tga_core.sv
src/tga_out_reg.sv
src/tga_image_stream_decoder.sv
src/tga_checker.sv
tb/sv/tb.sv
